// ===== rtl/core/lcfd_pkg.sv =====
package lcfd_pkg;

  localparam logic [7:0] CH_START = 8'h23;
  localparam logic [7:0] CH_END   = 8'h2A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_F     = 8'h66;

  localparam int unsigned BUF_DEPTH = 4;
  localparam int unsigned LEN_W     = 3;
  localparam int unsigned IDX_W     = 2;

  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(BUF_DEPTH);
  localparam logic [31:0] ADMIN_CODE_UNSET = 32'hFFFF_FFFF;

  // Last character of the command selects the operation.
  localparam logic [7:0] OP_OPEN  = 8'h30;
  localparam logic [7:0] OP_ALARM = 8'h31;
  localparam logic [7:0] OP_CODE  = 8'h32;

  typedef enum logic [1:0] {
    RESP_OPENED  = 2'd0,
    RESP_UNKNOWN = 2'd1,
    RESP_DONE    = 2'd2,
    RESP_BADPAR  = 2'd3
  } resp_t;

  typedef struct packed {
    resp_t       response;
    logic        open_door;
    logic        sound_alarm;
    logic        code_enabled;
    logic [31:0] stored_code;
  } lcfd_result_t;

endpackage

// ===== rtl/core/lcfd_if.sv =====
interface lcfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lcfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  response;
  logic        open_door;
  logic        sound_alarm;
  logic        code_enabled;
  logic [31:0] stored_code;

  modport source (
    output valid, output response, output open_door, output sound_alarm,
    output code_enabled, output stored_code, input ready
  );
  modport sink (
    input valid, input response, input open_door, input sound_alarm,
    input code_enabled, input stored_code, output ready
  );
endinterface

// ===== rtl/core/lcfd_frame_parser.sv =====
module lcfd_frame_parser
  import lcfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic [7:0]   rx_byte,
  input  logic         step,
  output logic         has_result,
  output lcfd_result_t result
);

  logic [7:0]       cmd_chars_r [BUF_DEPTH];
  logic [7:0]       par_chars_r [BUF_DEPTH];
  logic [LEN_W-1:0] cmd_len_r, cmd_len_nxt;
  logic [LEN_W-1:0] par_len_r, par_len_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic             in_param_r, in_param_nxt;
  logic [31:0]      admin_code_r, admin_code_nxt;
  logic             admin_on_r, admin_on_nxt;
  logic             cmd_wr, par_wr;

  logic       cmd_ok;
  logic       par_digits;
  logic       par_on, par_off;
  logic       exe_code_wr, exe_on_set, exe_off_set;
  resp_t      exe_resp;
  logic       exe_door, exe_alarm;

  // Command decode on the stored frame, used when the end marker arrives.
  assign cmd_ok = (cmd_len_r == LEN_FULL) && (cmd_chars_r[0] == CH_ZERO) &&
                  (cmd_chars_r[1] == CH_X) && (cmd_chars_r[2] == CH_ZERO) &&
                  (cmd_chars_r[3] inside {[CH_ZERO:CH_THREE]});

  always_comb begin
    par_digits = 1'b1;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      if (!(par_chars_r[i] inside {[CH_ZERO:CH_NINE]})) begin
        par_digits = 1'b0;
      end
    end
  end

  assign par_on  = (par_len_r == LEN_W'(2)) && (par_chars_r[0] == CH_O) &&
                   (par_chars_r[1] == CH_N);
  assign par_off = (par_len_r == LEN_W'(3)) && (par_chars_r[0] == CH_O) &&
                   (par_chars_r[1] == CH_F) && (par_chars_r[2] == CH_F);

  always_comb begin
    exe_resp    = RESP_BADPAR;
    exe_door    = 1'b0;
    exe_alarm   = 1'b0;
    exe_code_wr = 1'b0;
    exe_on_set  = 1'b0;
    exe_off_set = 1'b0;
    if (!cmd_ok) begin
      exe_resp = RESP_UNKNOWN;
    end else begin
      case (cmd_chars_r[3])
        OP_OPEN: begin
          if (par_len_r == '0) begin
            exe_resp = RESP_OPENED;
            exe_door = 1'b1;
          end
        end
        OP_ALARM: begin
          if (par_len_r == '0) begin
            exe_resp  = RESP_DONE;
            exe_alarm = 1'b1;
          end
        end
        OP_CODE: begin
          if (par_len_r == LEN_FULL && par_digits) begin
            exe_resp    = RESP_DONE;
            exe_code_wr = 1'b1;
          end
        end
        default: begin
          if (par_on) begin
            exe_resp   = RESP_DONE;
            exe_on_set = 1'b1;
          end else if (par_off) begin
            exe_resp    = RESP_DONE;
            exe_off_set = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    cmd_len_nxt        = cmd_len_r;
    par_len_nxt        = par_len_r;
    in_frame_nxt       = in_frame_r;
    in_param_nxt       = in_param_r;
    admin_code_nxt     = admin_code_r;
    admin_on_nxt       = admin_on_r;
    cmd_wr             = 1'b0;
    par_wr             = 1'b0;
    has_result         = 1'b0;
    result.response    = RESP_DONE;
    result.open_door   = 1'b0;
    result.sound_alarm = 1'b0;
    if (rx_byte == CH_START) begin
      in_frame_nxt = 1'b1;
      in_param_nxt = 1'b0;
      cmd_len_nxt  = '0;
      par_len_nxt  = '0;
    end else if (in_frame_r) begin
      if (rx_byte == CH_SPACE) begin
        if (in_param_r || cmd_len_r != LEN_FULL) begin
          has_result      = 1'b1;
          result.response = in_param_r ? RESP_BADPAR : RESP_UNKNOWN;
          in_frame_nxt    = 1'b0;
          in_param_nxt    = 1'b0;
          cmd_len_nxt     = '0;
          par_len_nxt     = '0;
        end else begin
          in_param_nxt = 1'b1;
          par_len_nxt  = '0;
        end
      end else if (rx_byte == CH_END) begin
        has_result         = 1'b1;
        result.response    = exe_resp;
        result.open_door   = exe_door;
        result.sound_alarm = exe_alarm;
        if (exe_code_wr) begin
          admin_code_nxt = {par_chars_r[0], par_chars_r[1], par_chars_r[2], par_chars_r[3]};
        end
        if (exe_on_set) begin
          admin_on_nxt = 1'b1;
        end else if (exe_off_set) begin
          admin_on_nxt = 1'b0;
        end
        in_frame_nxt = 1'b0;
        in_param_nxt = 1'b0;
        cmd_len_nxt  = '0;
        par_len_nxt  = '0;
      end else if (in_param_r) begin
        if (par_len_r >= LEN_FULL) begin
          has_result      = 1'b1;
          result.response = RESP_BADPAR;
          in_frame_nxt    = 1'b0;
          in_param_nxt    = 1'b0;
          cmd_len_nxt     = '0;
          par_len_nxt     = '0;
        end else begin
          par_wr      = 1'b1;
          par_len_nxt = par_len_r + LEN_W'(1);
        end
      end else begin
        if (cmd_len_r >= LEN_FULL) begin
          has_result      = 1'b1;
          result.response = RESP_UNKNOWN;
          in_frame_nxt    = 1'b0;
          in_param_nxt    = 1'b0;
          cmd_len_nxt     = '0;
          par_len_nxt     = '0;
        end else begin
          cmd_wr      = 1'b1;
          cmd_len_nxt = cmd_len_r + LEN_W'(1);
        end
      end
    end
    result.code_enabled = admin_on_nxt;
    result.stored_code  = admin_code_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_len_r    <= '0;
      par_len_r    <= '0;
      in_frame_r   <= 1'b0;
      in_param_r   <= 1'b0;
      admin_code_r <= ADMIN_CODE_UNSET;
      admin_on_r   <= 1'b0;
    end else if (step) begin
      cmd_len_r    <= cmd_len_nxt;
      par_len_r    <= par_len_nxt;
      in_frame_r   <= in_frame_nxt;
      in_param_r   <= in_param_nxt;
      admin_code_r <= admin_code_nxt;
      admin_on_r   <= admin_on_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && cmd_wr) begin
      cmd_chars_r[cmd_len_r[IDX_W-1:0]] <= rx_byte;
    end
    if (step && par_wr) begin
      par_chars_r[par_len_r[IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule

// ===== rtl/core/lcfd_out_stage.sv =====
module lcfd_out_stage
  import lcfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  lcfd_result_t load_data,
  output logic         free,
  lcfd_out_if.source   out_ch
);

  logic         valid_r, valid_nxt;
  lcfd_result_t data_r;

  // The register can take a new result when empty or when it drains this cycle.
  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.response     = data_r.response;
  assign out_ch.open_door    = data_r.open_door;
  assign out_ch.sound_alarm  = data_r.sound_alarm;
  assign out_ch.code_enabled = data_r.code_enabled;
  assign out_ch.stored_code  = data_r.stored_code;

endmodule

// ===== rtl/core/lock_command_frame_decoder_top.sv =====
// Lock command frame decoder.
// The input channel carries one received serial byte per beat. Frames have
// the form '#', a four character command, an optional space and parameter of
// up to four characters, then '*'. Bytes outside a frame are dropped silently.
// The output channel carries at most one response beat per input byte: the
// response code, door and alarm requests, and the admin code and its enable
// flag as they stand after that byte.
// Each byte is captured in an input register, decoded combinationally against
// the frame state, and its response lands in an output register. A byte passes
// the input register and then the output register on its way to its response
// beat, and one byte is taken every cycle as long as responses are drained.
// When the receiver stalls, the held response stays put; bytes that make no
// response keep flowing, and a byte that would make one waits in the input
// register until the output register frees, which then holds off the input.
// Synchronous reset clears both pipeline registers, ends any open frame, sets
// the admin code to unset (all ones) and disables it.
module lock_command_frame_decoder_top
  import lcfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  lcfd_in_if.sink    in_ch,
  lcfd_out_if.source out_ch
);

  logic         stage_valid_r, stage_valid_nxt;
  logic [7:0]   stage_byte_r;
  logic         has_result;
  lcfd_result_t result;
  logic         out_free;
  logic         advance;
  logic         in_fire;

  // The byte in the input register moves on when it makes no response or
  // when the output register can take its response.
  assign advance  = stage_valid_r && (!has_result || out_free);
  assign in_ch.ready = !stage_valid_r || advance;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (advance) begin
      stage_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      stage_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_byte_r <= in_ch.rx_byte;
    end
  end

  // Frame state, command decode and execution.
  lcfd_frame_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_byte    (stage_byte_r),
    .step       (advance),
    .has_result (has_result),
    .result     (result)
  );

  // Response register toward the output channel.
  lcfd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && has_result),
    .load_data (result),
    .free      (out_free),
    .out_ch    (out_ch)
  );

endmodule

// ===== dv/lcfd_checker.sv =====
`timescale 1ns / 1ps

module lcfd_checker
  import lcfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_response,
  input  logic        out_open_door,
  input  logic        out_sound_alarm,
  input  logic        out_code_enabled,
  input  logic [31:0] out_stored_code,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  // Shadow copy of the frame state and the admin code.
  logic [7:0]  cmd_buf [BUF_DEPTH];
  logic [2:0]  cmd_len;
  logic [7:0]  par_buf [BUF_DEPTH];
  logic [2:0]  par_len;
  logic        framing;
  logic        in_par;
  logic [31:0] admin_code_q;
  logic        admin_on_q;

  lcfd_result_t awaited_responses[$];
  int           errors;
  int           n_checked;

  function automatic lcfd_result_t make_response(resp_t resp, logic door, logic alarm);
    lcfd_result_t res;
    res.response     = resp;
    res.open_door    = door;
    res.sound_alarm  = alarm;
    res.code_enabled = admin_on_q;
    res.stored_code  = admin_code_q;
    return res;
  endfunction

  task automatic drop_frame();
    framing = 1'b0;
    in_par  = 1'b0;
    cmd_len = '0;
    par_len = '0;
  endtask

  // Runs the command on '*'. Only "0x00" to "0x03" are known.
  task automatic run_command(output lcfd_result_t res);
    logic [2:0]  plen;
    resp_t       resp;
    logic        door;
    logic        alarm;
    logic        digits_ok;
    logic [31:0] new_code;
    plen  = in_par ? par_len : 3'd0;
    resp  = RESP_BADPAR;
    door  = 1'b0;
    alarm = 1'b0;
    if (cmd_len != LEN_FULL || cmd_buf[0] != CH_ZERO || cmd_buf[1] != CH_X ||
        cmd_buf[2] != CH_ZERO || cmd_buf[3] < CH_ZERO || cmd_buf[3] > CH_THREE) begin
      resp = RESP_UNKNOWN;
    end else begin
      case (cmd_buf[3])
        OP_OPEN: begin
          if (plen == 3'd0) begin
            resp = RESP_OPENED;
            door = 1'b1;
          end
        end
        OP_ALARM: begin
          if (plen == 3'd0) begin
            resp  = RESP_DONE;
            alarm = 1'b1;
          end
        end
        OP_CODE: begin
          if (plen == LEN_FULL) begin
            digits_ok = 1'b1;
            new_code  = '0;
            for (int i = 0; i < BUF_DEPTH; i++) begin
              if (par_buf[i] < CH_ZERO || par_buf[i] > CH_NINE) digits_ok = 1'b0;
              new_code = {new_code[23:0], par_buf[i]};
            end
            if (digits_ok) begin
              admin_code_q = new_code;
              resp         = RESP_DONE;
            end
          end
        end
        default: begin
          if (plen == 3'd2 && par_buf[0] == CH_O && par_buf[1] == CH_N) begin
            admin_on_q = 1'b1;
            resp       = RESP_DONE;
          end else if (plen == 3'd3 && par_buf[0] == CH_O && par_buf[1] == CH_F &&
                       par_buf[2] == CH_F) begin
            admin_on_q = 1'b0;
            resp       = RESP_DONE;
          end
        end
      endcase
    end
    res = make_response(resp, door, alarm);
  endtask

  task automatic decode_rx_byte(input logic [7:0] b);
    lcfd_result_t res;
    if (b == CH_START) begin
      framing = 1'b1;
      in_par  = 1'b0;
      cmd_len = '0;
      par_len = '0;
    end else if (framing) begin
      if (b == CH_SPACE) begin
        if (in_par) begin
          drop_frame();
          awaited_responses.push_back(make_response(RESP_BADPAR, 1'b0, 1'b0));
        end else if (cmd_len != LEN_FULL) begin
          drop_frame();
          awaited_responses.push_back(make_response(RESP_UNKNOWN, 1'b0, 1'b0));
        end else begin
          in_par  = 1'b1;
          par_len = '0;
        end
      end else if (b == CH_END) begin
        run_command(res);
        drop_frame();
        awaited_responses.push_back(res);
      end else if (in_par) begin
        if (par_len >= LEN_FULL) begin
          drop_frame();
          awaited_responses.push_back(make_response(RESP_BADPAR, 1'b0, 1'b0));
        end else begin
          par_buf[par_len[IDX_W-1:0]] = b;
          par_len++;
        end
      end else if (cmd_len >= LEN_FULL) begin
        drop_frame();
        awaited_responses.push_back(make_response(RESP_UNKNOWN, 1'b0, 1'b0));
      end else begin
        cmd_buf[cmd_len[IDX_W-1:0]] = b;
        cmd_len++;
      end
    end
  endtask

  task automatic report_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  task automatic check_beat();
    lcfd_result_t exp_res;
    if (awaited_responses.size() == 0) begin
      $display("%0t: response beat with none expected, got response %0d", $time,
               out_response);
      errors++;
    end else begin
      exp_res = awaited_responses.pop_front();
      n_checked++;
      report_field("response", 32'(exp_res.response), 32'(out_response));
      report_field("open_door", 32'(exp_res.open_door), 32'(out_open_door));
      report_field("sound_alarm", 32'(exp_res.sound_alarm), 32'(out_sound_alarm));
      report_field("code_enabled", 32'(exp_res.code_enabled), 32'(out_code_enabled));
      report_field("stored_code", exp_res.stored_code, out_stored_code);
    end
  endtask

  initial begin
    errors    = 0;
    n_checked = 0;
  end

  // Beats are sampled at the rising edge; the results go out by nonblocking
  // assignment so the stimulus side always sees a settled value.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUF_DEPTH; i++) begin
        cmd_buf[i] = '0;
        par_buf[i] = '0;
      end
      drop_frame();
      admin_code_q = ADMIN_CODE_UNSET;
      admin_on_q   = 1'b0;
      awaited_responses.delete();
    end else begin
      if (in_valid && in_ready) decode_rx_byte(in_rx_byte);
      if (out_valid && out_ready) check_beat();
    end
    fail_count <= errors;
    pending    <= awaited_responses.size();
    checked    <= n_checked;
  end

endmodule

// ===== dv/lock_command_frame_decoder_top_test.sv =====
`timescale 1ns / 1ps

module lock_command_frame_decoder_top_test;
  import lcfd_pkg::*;

  // Frame bytes to send in all; noise outside frames is extra.
  localparam int ITEM_TARGET    = 650;
  // Cycles the receiver holds off during the backpressure burst.
  localparam int HOLD_CYCLES    = 80;
  // Longest legal stretch without a beat is the hold-off or a long gap, far
  // below this.
  localparam int WATCHDOG_LIMIT = 1000;

  logic clk;
  logic rst_n;

  lcfd_in_if  in_ch();
  lcfd_out_if out_ch();

  int fail_count;
  int pending;
  int checked;

  // Shared knobs: calm turns off all idling on both sides; hold_req asks the
  // receiver for one long hold-off.
  bit calm;
  bit hold_req;

  logic [7:0] frame_q[$];
  int useful_bytes;
  int frames_sent;

  lock_command_frame_decoder_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // The checker watches both channels beside the block, predicts every
  // response beat and counts the failures.
  lcfd_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_rx_byte       (in_ch.rx_byte),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_response     (out_ch.response),
    .out_open_door    (out_ch.open_door),
    .out_sound_alarm  (out_ch.sound_alarm),
    .out_code_enabled (out_ch.code_enabled),
    .out_stored_code  (out_ch.stored_code),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = ~clk;
  end

  // Idle length between beats: mostly none, sometimes a short gap and now
  // and then a long gap.
  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Any byte value, with the two extremes weighted up.
  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Command characters leaning toward the "0x0n" shape so near misses are
  // common.
  function automatic logic [7:0] cmd_char();
    case ($urandom_range(0, 3))
      0: return CH_ZERO;
      1: return CH_X;
      2: return CH_ZERO + 8'($urandom_range(0, 3));
      default: return any_byte();
    endcase
  endfunction

  function automatic logic [7:0] known_op();
    return CH_ZERO + 8'($urandom_range(0, 3));
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endtask

  // Offers one byte and returns at the edge where it is accepted. A gap that
  // follows drops valid; with no gap valid simply stays high for the next
  // byte, so valid never gets two assignments in one step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    gap = idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input bit counts);
    if (counts) begin
      useful_bytes += frame_q.size();
      frames_sent++;
    end
    while (frame_q.size() > 0) send_byte(frame_q.pop_front());
  endtask

  // Stops offering and waits until every predicted response has come back.
  task automatic drain_responses();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Well-formed frame: "#0x0" plus an operation character, a parameter that
  // suits the operation most of the time, and the closing '*'.
  task automatic add_good_frame();
    logic [7:0] op;
    int r;
    int n;
    int bad;
    if ($urandom_range(0, 9) == 0) op = CH_ZERO + 8'($urandom_range(4, 9));
    else op = known_op();
    push_text("#0x0");
    frame_q.push_back(op);
    r = $urandom_range(0, 99);
    if (op == OP_CODE) begin
      if (r < 85) begin
        // A four digit code, sometimes with one character spoiled.
        bad = (r < 70) ? -1 : $urandom_range(0, 3);
        frame_q.push_back(CH_SPACE);
        for (int i = 0; i < 4; i++) frame_q.push_back(i == bad ? any_byte() : digit());
      end else begin
        n = $urandom_range(0, 3);
        if (n > 0 || $urandom_range(0, 1)) frame_q.push_back(CH_SPACE);
        repeat (n) frame_q.push_back(digit());
      end
    end else if (op == CH_THREE) begin
      if (r < 40) push_text(" on");
      else if (r < 80) push_text(" off");
      else begin
        frame_q.push_back(CH_SPACE);
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(0, 3))
            0: frame_q.push_back(CH_O);
            1: frame_q.push_back(CH_N);
            2: frame_q.push_back(CH_F);
            default: frame_q.push_back(any_byte());
          endcase
        end
      end
    end else if (r >= 50) begin
      // Open, alarm and unknown operations: a bare space or a stray
      // parameter.
      frame_q.push_back(CH_SPACE);
      if (r >= 70) repeat ($urandom_range(1, 4)) frame_q.push_back(any_byte());
    end
    frame_q.push_back(CH_END);
  endtask

  // Command of random length and content: short commands before a space,
  // overlong commands and commands that match nothing.
  task automatic add_free_frame();
    frame_q.push_back(CH_START);
    repeat ($urandom_range(0, 5)) frame_q.push_back(cmd_char());
    if ($urandom_range(0, 1)) begin
      frame_q.push_back(CH_SPACE);
      repeat ($urandom_range(0, 4)) frame_q.push_back(any_byte());
    end
    frame_q.push_back(CH_END);
  endtask

  // Parameter errors: a fifth parameter character or a second space. The
  // trailing '*' lands outside the frame once it has been aborted.
  task automatic add_broken_frame();
    push_text("#0x0");
    frame_q.push_back(known_op());
    frame_q.push_back(CH_SPACE);
    if ($urandom_range(0, 1)) begin
      repeat (5) frame_q.push_back(digit());
    end else begin
      repeat ($urandom_range(0, 3)) frame_q.push_back(digit());
      frame_q.push_back(CH_SPACE);
    end
    if ($urandom_range(0, 1)) frame_q.push_back(CH_END);
  endtask

  // A '#' in the middle of a frame starts over.
  task automatic add_restart_frame();
    push_text("#0x");
    repeat ($urandom_range(0, 2)) frame_q.push_back(digit());
    if ($urandom_range(0, 1)) frame_q.push_back(CH_SPACE);
    add_good_frame();
  endtask

  // Bytes between frames, which the block must drop without a response.
  task automatic add_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 6)) begin
      b = any_byte();
      if (b == CH_START) b = CH_END;
      frame_q.push_back(b);
    end
  endtask

  // Receiver: random stalls of mostly short and a few long lengths, none at
  // all while calm, and one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm) begin
        stall_left = 0;
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0: stall_left = $urandom_range(8, 30);
          1, 2, 3, 4, 5: stall_left = $urandom_range(1, 3);
          default: stall_left = 0;
        endcase
        out_ch.ready <= (stall_left == 0);
      end
    end
  end

  // Watchdog: ends the run if no beat moves on either channel for too long.
  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_run = 0;
      else idle_run++;
    end
    $display("%0t: watchdog expired after %0d cycles without a beat, %0d responses pending",
             $time, WATCHDOG_LIMIT, pending);
    $display("lock_command_frame_decoder_top_test NOT OK");
    $finish;
  end

  initial begin
    bit pressure_done;
    int kind;
    pressure_done = 1'b0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    useful_bytes  = 0;
    frames_sent   = 0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: a byte outside any frame, then opening the door, the
    // alarm and storing a code, the first two seen against the unset code.
    push_text("Z#0x00*#0x01*#0x02 9999*");
    send_frame(1'b1);
    drain_responses();

    while (useful_bytes < ITEM_TARGET) begin
      if (!pressure_done && useful_bytes >= 250) begin
        // Backpressure: the receiver holds off while the sender keeps
        // offering frames that each make a response, so both pipeline
        // registers fill and the input stalls. Then everything drains.
        pressure_done = 1'b1;
        calm          = 1'b1;
        hold_req      = 1'b1;
        repeat (24) push_text("#*");
        send_frame(1'b1);
        calm = 1'b0;
        drain_responses();
      end
      if ($urandom_range(0, 9) == 0) calm = ~calm;
      kind = $urandom_range(0, 99);
      if (kind < 60) add_good_frame();
      else if (kind < 75) add_free_frame();
      else if (kind < 85) add_broken_frame();
      else if (kind < 92) add_restart_frame();
      if (kind < 92) begin
        send_frame(1'b1);
      end else begin
        add_noise();
        send_frame(1'b0);
      end
      if ($urandom_range(0, 19) == 0) drain_responses();
    end

    drain_responses();
    repeat (10) @(posedge clk);

    $display("Covered %0d frame bytes in %0d frames plus noise, %0d responses checked,",
             useful_bytes, frames_sent, checked);
    $display("with a long receiver hold-off, drained pauses and random idling.");
    if (fail_count == 0) begin
      $display("lock_command_frame_decoder_top_test OK");
    end else begin
      $display("lock_command_frame_decoder_top_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lcfd_pkg.sv
rtl/core/lcfd_if.sv
rtl/core/lcfd_frame_parser.sv
rtl/core/lcfd_out_stage.sv
rtl/core/lock_command_frame_decoder_top.sv
dv/lcfd_checker.sv
dv/lock_command_frame_decoder_top_test.sv
